// ----- sv/fmrt_pkg.sv -----
// Shared types, codes and rule match functions of the packet rule table.
`timescale 1ns / 1ps

package fmrt_pkg;

  // table geometry
  localparam int MAX_RULES = 64;
  localparam int CNT_W     = $clog2(MAX_RULES + 1);

  // request kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_TEST   = 2'd2;

  // address test modes
  localparam logic [1:0] ADDR_EXACT  = 2'd0;
  localparam logic [1:0] ADDR_PREFIX = 2'd1;
  localparam logic [1:0] ADDR_ANY    = 2'd2;

  // port test modes
  localparam logic [1:0] PORT_EXACT = 2'd0;
  localparam logic [1:0] PORT_RANGE = 2'd1;
  localparam logic [1:0] PORT_ANY   = 2'd2;

  // protocol test modes
  localparam logic [1:0] PROTO_TCP = 2'd0;
  localparam logic [1:0] PROTO_UDP = 2'd1;
  localparam logic [1:0] PROTO_ANY = 2'd2;

  // IP protocol numbers
  localparam logic [7:0] IP_NUM_TCP = 8'd6;
  localparam logic [7:0] IP_NUM_UDP = 8'd17;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [5:0] ADDR_BITS = 6'd32;

  // request payload
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] rule_id;
    logic [1:0]  addr_mode;
    logic [31:0] addr;
    logic [5:0]  prefix_len;
    logic [1:0]  port_mode;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic [1:0]  proto_mode;
    logic        rule_action;
    logic [7:0]  pkt_proto;
  } fmrt_in_t;

  // result payload
  typedef struct packed {
    logic [1:0] status;
    logic       verdict;
    logic       rule_hit;
  } fmrt_out_t;

  // one stored rule
  typedef struct packed {
    logic [31:0] addr;
    logic [5:0]  prefix_len;
    logic [1:0]  addr_mode;
    logic [1:0]  port_mode;
    logic [1:0]  proto_mode;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic [15:0] rule_id;
    logic        action;
  } fmrt_rule_t;

  // search token that walks down the cell chain
  typedef struct packed {
    logic vld;
    logic found;
    logic verdict;
  } fmrt_probe_t;

  // broadcast command to every cell
  typedef struct packed {
    logic      remove;
    logic      add_en;
    fmrt_in_t  req;
  } fmrt_cmd_t;

  // build a rule from an add request
  function automatic fmrt_rule_t to_rule(input fmrt_in_t r);
    fmrt_rule_t w;
    w.addr       = r.addr;
    w.prefix_len = r.prefix_len;
    w.addr_mode  = r.addr_mode;
    w.port_mode  = r.port_mode;
    w.proto_mode = r.proto_mode;
    w.port_low   = r.port_low;
    w.port_high  = r.port_high;
    w.rule_id    = r.rule_id;
    w.action     = r.rule_action;
    return w;
  endfunction

  // all three tests of one rule against a packet
  function automatic logic rule_match(input fmrt_rule_t w, input fmrt_in_t p);
    logic [5:0]  plen;
    logic [31:0] mask;
    logic        a_ok;
    logic        p_ok;
    logic        t_ok;
    plen = (w.prefix_len > ADDR_BITS) ? ADDR_BITS : w.prefix_len;
    mask = 32'hFFFF_FFFF << (ADDR_BITS - plen);
    case (w.addr_mode)
      ADDR_EXACT:  a_ok = (w.addr == p.addr);
      // zero length matches all; rule address compared unmasked
      ADDR_PREFIX: a_ok = (plen == 6'd0) || ((p.addr & mask) == w.addr);
      ADDR_ANY:    a_ok = 1'b1;
      default:     a_ok = 1'b0;
    endcase
    case (w.port_mode)
      PORT_EXACT: p_ok = (p.port_low == w.port_low);
      PORT_RANGE: p_ok = (p.port_low >= w.port_low) && (p.port_low <= w.port_high);
      PORT_ANY:   p_ok = 1'b1;
      default:    p_ok = 1'b0;
    endcase
    case (w.proto_mode)
      PROTO_TCP: t_ok = (p.pkt_proto == IP_NUM_TCP);
      PROTO_UDP: t_ok = (p.pkt_proto == IP_NUM_UDP);
      PROTO_ANY: t_ok = 1'b1;
      default:   t_ok = 1'b0;
    endcase
    return a_ok & p_ok & t_ok;
  endfunction

endpackage

// ----- sv/first_match_packet_rule_table_unit.sv -----
// Top level of the first-match packet rule table. Requests are taken when
// start is high and busy is low; every request gives one result, shown for
// one cycle with out_valid, and the receiver cannot stall it. An add or an
// unused kind is answered from the exec state. A test or a remove sends
// a probe down the row of MAX_RULES rule cells, one cell per cycle, so it
// always walks the whole row whatever the rule count; a remove closes the gap
// as the probe passes. default_action resets to drop (1).
`timescale 1ns / 1ps

module first_match_packet_rule_table_unit
  import fmrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  fmrt_in_t  in_req,
  output logic      out_valid,
  output fmrt_out_t out_res,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]       state_r,   state_nxt;
  logic [CNT_W-1:0] count_r,   count_nxt;
  fmrt_in_t         req_r,     req_nxt;
  logic             strobe_r,  strobe_nxt;
  fmrt_out_t        res_r,     res_nxt;
  logic             dflt_r;
  fmrt_cmd_t        cmd;
  fmrt_probe_t      probe_head;
  fmrt_probe_t      probe_tail;
  logic             full;
  logic             accept;

  assign accept = start && (state_r == ST_IDLE);
  assign full   = (count_r == CNT_W'(MAX_RULES));

  // broadcast to the cells
  always_comb begin
    cmd.req    = req_r;
    cmd.remove = (req_r.kind == KIND_REMOVE);
    cmd.add_en = (state_r == ST_EXEC) && (req_r.kind == KIND_ADD) && !full;
  end

  // probe enters cell 0 in the exec cycle of a test or remove
  always_comb begin
    probe_head.vld     = (state_r == ST_EXEC)
                         && (req_r.kind inside {KIND_TEST, KIND_REMOVE});
    probe_head.found   = 1'b0;
    probe_head.verdict = dflt_r;
  end

  // request sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    req_nxt    = req_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt   = in_req;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_nxt = '0;
        case (req_r.kind)
          KIND_ADD: begin
            strobe_nxt = 1'b1;
            state_nxt  = ST_IDLE;
            if (full) begin
              res_nxt.status = STATUS_FULL;
            end else begin
              count_nxt = count_r + CNT_W'(1);
            end
          end
          KIND_REMOVE, KIND_TEST: begin
            state_nxt = ST_SCAN;
          end
          default: begin
            strobe_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        if (probe_tail.vld) begin
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
          res_nxt    = '0;
          if (req_r.kind == KIND_REMOVE) begin
            if (probe_tail.found) begin
              count_nxt = count_r - CNT_W'(1);
            end else begin
              res_nxt.status = STATUS_NOT_FOUND;
            end
          end else begin
            res_nxt.verdict  = probe_tail.verdict;
            res_nxt.rule_hit = probe_tail.found;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
      dflt_r   <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_we) begin
        dflt_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

  fmrt_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .rule_count (count_r),
    .probe_head (probe_head),
    .probe_tail (probe_tail)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = strobe_r;
  assign out_res   = res_r;

endmodule

// ----- sv/fmrt_cell.sv -----
// One rule cell: holds a rule, tests the passing probe, shifts up on remove.
`timescale 1ns / 1ps

module fmrt_cell
  import fmrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  fmrt_cmd_t   cmd,
  input  logic        occupied,
  input  logic        wr_en,
  input  fmrt_rule_t  nbr_rule,
  input  fmrt_probe_t probe_in,
  output fmrt_rule_t  rule,
  output fmrt_probe_t probe_out
);

  fmrt_rule_t  rule_r,  rule_nxt;
  fmrt_probe_t probe_r, probe_nxt;
  logic        cand;
  logic        hit_here;

  // local test: id compare on remove, packet match on test
  assign cand     = cmd.remove ? (rule_r.rule_id == cmd.req.rule_id)
                               : rule_match(rule_r, cmd.req);
  assign hit_here = probe_in.vld & ~probe_in.found & occupied & cand;

  // probe hand-off to the next cell
  always_comb begin
    probe_nxt.vld     = probe_in.vld;
    probe_nxt.found   = probe_in.found | hit_here;
    probe_nxt.verdict = hit_here ? rule_r.action : probe_in.verdict;
  end

  // append write, or take the neighbor's rule at and after the removed one
  always_comb begin
    rule_nxt = rule_r;
    if (cmd.add_en && wr_en) begin
      rule_nxt = to_rule(cmd.req);
    end else if (cmd.remove && probe_in.vld && (probe_in.found || hit_here)) begin
      rule_nxt = nbr_rule;
    end
  end

  always_ff @(posedge clk) begin
    rule_r <= rule_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  assign rule      = rule_r;
  assign probe_out = probe_r;

endmodule

// ----- sv/fmrt_chain.sv -----
// Row of rule cells with per-cell occupancy and append select.
`timescale 1ns / 1ps

module fmrt_chain
  import fmrt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  fmrt_cmd_t        cmd,
  input  logic [CNT_W-1:0] rule_count,
  input  fmrt_probe_t      probe_head,
  output fmrt_probe_t      probe_tail
);

  fmrt_probe_t probe [MAX_RULES+1];
  fmrt_rule_t  rules [MAX_RULES];

  assign probe[0]   = probe_head;
  assign probe_tail = probe[MAX_RULES];

  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    logic       occ;
    logic       wr;
    fmrt_rule_t nbr;

    assign occ = (CNT_W'(i) < rule_count);
    assign wr  = (CNT_W'(i) == rule_count);

    // last cell has no neighbor; what it copies lies beyond the count
    if (i == MAX_RULES - 1) begin : g_last
      assign nbr = rules[i];
    end else begin : g_mid
      assign nbr = rules[i+1];
    end

    fmrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .occupied  (occ),
      .wr_en     (wr),
      .nbr_rule  (nbr),
      .probe_in  (probe[i]),
      .rule      (rules[i]),
      .probe_out (probe[i+1])
    );
  end

endmodule

// ----- sv/fmrt_checker.sv -----
// Port-level checks of the packet rule table, bound to the top level.
`timescale 1ns / 1ps

module fmrt_checker
  import fmrt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input fmrt_out_t out_res
);

  // an accepted request holds the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // a result only appears once the block is free again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // every request passes through the exec state after accept, so strobes never touch
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // a rule hit only comes from a test, whose status is ok
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.rule_hit |-> out_res.status == STATUS_OK)
    else $error("rule hit with non-ok status");

endmodule

bind first_match_packet_rule_table_unit fmrt_checker u_fmrt_checker (.*);

// ----- tb/fmrt_result_checker.sv -----
// Result checker for the packet rule table: tracks the rule list and flags bad results.
`timescale 1ns / 1ps

module fmrt_result_checker
  import fmrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  fmrt_in_t  in_req,
  input  logic      out_valid,
  input  fmrt_out_t out_res,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  output int        mismatch_count,
  output int        results_owed
);

  // shadow copy of the rule list, in priority order
  fmrt_rule_t  shadow_rules [MAX_RULES];
  int unsigned shadow_total;
  logic        fallback_verdict;

  // results still owed by the block, oldest first
  fmrt_out_t   owed_results [$];

  initial begin
    mismatch_count   = 0;
    results_owed     = 0;
    shadow_total     = 0;
    fallback_verdict = 1'b1;
  end

  task automatic note_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // address test; a prefix keeps the top len bits of the packet address
  function automatic logic addr_passes(input fmrt_rule_t r, input logic [31:0] pkt);
    int unsigned len;
    logic [31:0] keep;
    len = r.prefix_len;
    if (len > 32) len = 32;
    keep = ~(32'hFFFF_FFFF >> len);
    case (r.addr_mode)
      ADDR_EXACT:  return pkt == r.addr;
      ADDR_PREFIX: return (len == 0) || ((pkt & keep) == r.addr);
      ADDR_ANY:    return 1'b1;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic port_passes(input fmrt_rule_t r, input logic [15:0] port);
    case (r.port_mode)
      PORT_EXACT: return port == r.port_low;
      PORT_RANGE: return (port >= r.port_low) && (port <= r.port_high);
      PORT_ANY:   return 1'b1;
      default:    return 1'b0;
    endcase
  endfunction

  function automatic logic proto_passes(input fmrt_rule_t r, input logic [7:0] proto);
    case (r.proto_mode)
      PROTO_TCP: return proto == IP_NUM_TCP;
      PROTO_UDP: return proto == IP_NUM_UDP;
      PROTO_ANY: return 1'b1;
      default:   return 1'b0;
    endcase
  endfunction

  // apply one request to the shadow list and work out its result
  task automatic serve_request(input fmrt_in_t q, output fmrt_out_t res);
    fmrt_rule_t fresh;
    logic       done;
    res  = '0;
    done = 1'b0;
    case (q.kind)
      KIND_ADD: begin
        if (shadow_total >= MAX_RULES) begin
          res.status = STATUS_FULL;
        end else begin
          fresh.addr       = q.addr;
          fresh.prefix_len = q.prefix_len;
          fresh.addr_mode  = q.addr_mode;
          fresh.port_mode  = q.port_mode;
          fresh.proto_mode = q.proto_mode;
          fresh.port_low   = q.port_low;
          fresh.port_high  = q.port_high;
          fresh.rule_id    = q.rule_id;
          fresh.action     = q.rule_action;
          shadow_rules[shadow_total] = fresh;
          shadow_total++;
        end
      end
      KIND_REMOVE: begin
        res.status = STATUS_NOT_FOUND;
        for (int unsigned i = 0; i < shadow_total; i++) begin
          if (!done && shadow_rules[i].rule_id == q.rule_id) begin
            // close the gap, keeping order
            for (int unsigned j = i; j + 1 < shadow_total; j++)
              shadow_rules[j] = shadow_rules[j + 1];
            done = 1'b1;
          end
        end
        if (done) begin
          shadow_total--;
          res.status = STATUS_OK;
        end
      end
      KIND_TEST: begin
        res.verdict = fallback_verdict;
        for (int unsigned i = 0; i < shadow_total; i++) begin
          if (!done && addr_passes(shadow_rules[i], q.addr)
              && port_passes(shadow_rules[i], q.port_low)
              && proto_passes(shadow_rules[i], q.pkt_proto)) begin
            res.verdict  = shadow_rules[i].action;
            res.rule_hit = 1'b1;
            done         = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  // watch both channels and the config port at each rising edge
  always @(posedge clk) begin
    fmrt_out_t want;
    if (!rst_n) begin
      shadow_total     = 0;
      fallback_verdict = 1'b1;
      owed_results.delete();
    end else begin
      if (out_valid) begin
        if (owed_results.size() == 0) begin
          note_mismatch("result with no request outstanding");
        end else begin
          want = owed_results.pop_front();
          if (out_res.status !== want.status)
            note_mismatch($sformatf("status got %0d want %0d", out_res.status, want.status));
          if (out_res.verdict !== want.verdict)
            note_mismatch($sformatf("verdict got %0d want %0d",
                                    out_res.verdict, want.verdict));
          if (out_res.rule_hit !== want.rule_hit)
            note_mismatch($sformatf("rule_hit got %0d want %0d",
                                    out_res.rule_hit, want.rule_hit));
        end
      end
      if (cfg_we) fallback_verdict = cfg_wdata;
      if (start && !busy) begin
        serve_request(in_req, want);
        owed_results.push_back(want);
      end
    end
    results_owed = owed_results.size();
  end

endmodule

// ----- tb/first_match_packet_rule_table_unit_tb.sv -----
// Testbench top for the packet rule table: reset, request stimulus and the final verdict.
`timescale 1ns / 1ps

module first_match_packet_rule_table_unit_tb;
  import fmrt_pkg::*;

  // codes with no name in the package
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] MODE_NEVER  = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  fmrt_in_t  in_req;
  logic      out_valid;
  fmrt_out_t out_res;
  logic      cfg_we;
  logic      cfg_wdata;
  int        mismatch_count;
  int        results_owed;
  logic      no_idle;

  always #10 clk = ~clk;

  first_match_packet_rule_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  fmrt_result_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req         (in_req),
    .out_valid      (out_valid),
    .out_res        (out_res),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // small pools so that rules and packets collide often
  function automatic logic [15:0] pick_id();
    case ($urandom_range(0, 7))
      0:       return 16'hFFFF;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(0, 11));
    endcase
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 9))
      0:       return 32'h0A00_0001;
      1:       return 32'hC0A8_0100;
      2:       return 32'hC0A8_01FE;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0000;
      5:       return 32'hAC10_0000;
      6:       return 32'h0A00_00FF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 8))
      0:       return 16'd0;
      1:       return 16'd80;
      2:       return 16'd443;
      3:       return 16'd1000;
      4:       return 16'd1500;
      5:       return 16'd2000;
      6:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_mode();
    return ($urandom_range(0, 19) == 0) ? MODE_NEVER : 2'($urandom_range(0, 2));
  endfunction

  // random request; fields the kind does not use keep their noise
  function automatic fmrt_in_t random_request(input int add_pct, input int rm_pct);
    logic [127:0] noise;
    fmrt_in_t     r;
    int           roll;
    int unsigned  len;
    logic [15:0]  swap;
    noise = {$urandom, $urandom, $urandom, $urandom};
    r     = noise[$bits(fmrt_in_t)-1:0];
    roll  = $urandom_range(0, 99);
    if (roll < 2) begin
      r.kind = KIND_UNUSED;
    end else if (roll < 2 + add_pct) begin
      r.kind       = KIND_ADD;
      r.rule_id    = pick_id();
      r.addr_mode  = pick_mode();
      r.port_mode  = pick_mode();
      r.proto_mode = pick_mode();
      r.addr       = pick_addr();
      r.port_low   = pick_port();
      r.port_high  = pick_port();
      r.prefix_len = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                                 : 6'($urandom_range(0, 32));
      // mostly store a clean prefix so that it can match
      if (r.addr_mode == ADDR_PREFIX && $urandom_range(0, 3) != 0) begin
        len    = (r.prefix_len > 32) ? 32 : r.prefix_len;
        r.addr = r.addr & ~(32'hFFFF_FFFF >> len);
      end
      // mostly an ordered range
      if (r.port_low > r.port_high && $urandom_range(0, 4) != 0) begin
        swap        = r.port_low;
        r.port_low  = r.port_high;
        r.port_high = swap;
      end
    end else if (roll < 2 + add_pct + rm_pct) begin
      r.kind    = KIND_REMOVE;
      r.rule_id = pick_id();
    end else begin
      r.kind     = KIND_TEST;
      r.addr     = pick_addr();
      if ($urandom_range(0, 2) == 0) r.addr[7:0] = 8'($urandom);
      r.port_low = pick_port();
      case ($urandom_range(0, 3))
        0, 1:    r.pkt_proto = IP_NUM_TCP;
        2:       r.pkt_proto = IP_NUM_UDP;
        default: r.pkt_proto = 8'($urandom);
      endcase
    end
    return r;
  endfunction

  function automatic fmrt_in_t make_add(input logic [15:0] id, input logic [1:0] am,
                                        input logic [31:0] a, input logic [5:0] plen,
                                        input logic [1:0] pm, input logic [15:0] lo,
                                        input logic [15:0] hi, input logic [1:0] tm,
                                        input logic act);
    fmrt_in_t r;
    r             = '0;
    r.kind        = KIND_ADD;
    r.rule_id     = id;
    r.addr_mode   = am;
    r.addr        = a;
    r.prefix_len  = plen;
    r.port_mode   = pm;
    r.port_low    = lo;
    r.port_high   = hi;
    r.proto_mode  = tm;
    r.rule_action = act;
    return r;
  endfunction

  function automatic fmrt_in_t make_test(input logic [31:0] a, input logic [15:0] port,
                                         input logic [7:0] proto);
    fmrt_in_t r;
    r           = '0;
    r.kind      = KIND_TEST;
    r.addr      = a;
    r.port_low  = port;
    r.pkt_proto = proto;
    return r;
  endfunction

  function automatic fmrt_in_t make_remove(input logic [15:0] id);
    fmrt_in_t r;
    r         = '0;
    r.kind    = KIND_REMOVE;
    r.rule_id = id;
    return r;
  endfunction

  // send one request; entered and left at a falling edge
  task automatic issue(input fmrt_in_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start  <= 1'b0;
      in_req <= random_request(50, 25);
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // hold off until every owed result has come back
  task automatic drain();
    start <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  task automatic set_default(input logic v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // stimulus
  initial begin
    int   add_pct;
    int   rm_pct;
    logic dflt;
    in_req    = '0;
    start     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    no_idle   = 1'b0;
    rst_n     = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, unused kind, then one rule per special case
    issue(make_test(32'h0A00_0001, 16'd80, IP_NUM_TCP));
    issue(make_remove(16'd5));
    issue('{kind: KIND_UNUSED, default: '0});
    issue(make_add(16'd1, ADDR_EXACT, 32'h0A00_0001, 6'd0,
                   PORT_EXACT, 16'd80, 16'd0, PROTO_TCP, 1'b0));
    issue(make_add(16'd2, ADDR_PREFIX, 32'hC0A8_0100, 6'd24,
                   PORT_RANGE, 16'd1000, 16'd2000, PROTO_UDP, 1'b1));
    // low bits set on a prefix rule: never matches
    issue(make_add(16'd3, ADDR_PREFIX, 32'hC0A8_0155, 6'd24,
                   PORT_ANY, 16'd0, 16'd0, PROTO_ANY, 1'b0));
    // over-long prefix acts as a full mask
    issue(make_add(16'hFFFF, ADDR_PREFIX, 32'hFFFF_FFFF, 6'd40,
                   PORT_EXACT, 16'hFFFF, 16'hFFFF, PROTO_ANY, 1'b0));
    issue(make_add(16'd5, MODE_NEVER, 32'h0, 6'd0, PORT_ANY, 16'd0, 16'd0, PROTO_ANY, 1'b0));
    // inverted range
    issue(make_add(16'd6, ADDR_ANY, 32'h0, 6'd0, PORT_RANGE, 16'd500, 16'd100,
                   PROTO_ANY, 1'b0));
    issue(make_add(16'd7, ADDR_ANY, 32'h0, 6'd0, MODE_NEVER, 16'd0, 16'd0, PROTO_ANY, 1'b0));
    issue(make_add(16'd8, ADDR_ANY, 32'h0, 6'd0, PORT_ANY, 16'd0, 16'd0, MODE_NEVER, 1'b0));
    // duplicate id with a zero-length prefix
    issue(make_add(16'd2, ADDR_PREFIX, 32'h1234_5678, 6'd0,
                   PORT_ANY, 16'd0, 16'd0, PROTO_TCP, 1'b0));
    issue(make_test(32'h0A00_0001, 16'd80, IP_NUM_TCP));
    issue(make_test(32'hC0A8_01FE, 16'd1500, IP_NUM_UDP));
    issue(make_test(32'hC0A8_0155, 16'd9, IP_NUM_UDP));
    issue(make_test(32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
    issue(make_test(32'h0102_0304, 16'd0, IP_NUM_TCP));
    issue(make_remove(16'd2));
    issue(make_test(32'hC0A8_01FE, 16'd1500, IP_NUM_UDP));
    set_default(1'b0);
    issue(make_test(32'hC0A8_01FE, 16'd1500, IP_NUM_UDP));
    issue(make_remove(16'hFFFF));
    issue(make_remove(16'hFFFF));
    issue(make_remove(16'd2));

    // random phases: fill to full, drain, mixed; default flips between phases
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       begin add_pct = 60; rm_pct = 10; dflt = 1'b1; end
        1:       begin add_pct = 70; rm_pct = 5;  dflt = 1'b0; end
        2:       begin add_pct = 20; rm_pct = 40; dflt = 1'b1; end
        3:       begin add_pct = 40; rm_pct = 20; dflt = 1'b0; end
        4:       begin add_pct = 50; rm_pct = 15; dflt = 1'b1; end
        default: begin add_pct = 10; rm_pct = 50; dflt = 1'b0; end
      endcase
      set_default(dflt);
      for (int n = 0; n < 275; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if (n == 137) drain();
        issue(random_request(add_pct, rm_pct));
      end
    end

    drain();
    repeat (MAX_RULES + 4) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("first_match_packet_rule_table_unit_tb: done, clean");
    end else begin
      $display("first_match_packet_rule_table_unit_tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("first_match_packet_rule_table_unit_tb: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/fmrt_pkg.sv
sv/fmrt_cell.sv
sv/fmrt_chain.sv
sv/first_match_packet_rule_table_unit.sv
sv/fmrt_checker.sv
tb/fmrt_result_checker.sv
tb/first_match_packet_rule_table_unit_tb.sv
